// ===== hdl/line_scan_smooth_centroid_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the line scan smoothing block
// Each macro expands to one concurrent assertion in simulation and to nothing
// when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef LINE_SCAN_SMOOTH_CENTROID_ASSERT_SVH
`define LINE_SCAN_SMOOTH_CENTROID_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define LSSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lssc assertion failed");
// next-cycle implication
`define LSSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lssc assertion failed");
`else
`define LSSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LSSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== hdl/lssc_pkg.sv =====
// ----------------------------------------------------------------------------
// lssc_pkg
// Shared constants and types of the line scan smoothing and centroid block.
// ----------------------------------------------------------------------------
`default_nettype none

package lssc_pkg;

    // parameter defaults
    localparam int unsigned LINE_LENGTH_DEF = 128;
    localparam int unsigned SAMPLE_BITS_DEF = 14;

    // fixed field widths of the stream items
    localparam int unsigned PIXEL_W     = 14;
    localparam int unsigned INDEX_W     = 7;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 32;

    // depth of the queue between front and back
    localparam int unsigned QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        DIV_3,
        DIV_4,
        DIV_5
    } t_div_kind;

    // which of the up to three results of one pixel is in work
    typedef enum logic [1:0] {
        PH_MAIN,
        PH_PREV,
        PH_TAIL
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SCALE,
        ST_WMUL,
        ST_WADD,
        ST_DIV,
        ST_EMIT
    } t_back_state;

    // classification of one accepted pixel
    typedef struct packed {
        logic      emit_main;  // smoothed pixel i-2 is due
        t_div_kind main_div;   // averaging width for pixel i-2
        logic      emit_prev;  // line ends and pixel i-1 exists
        logic      line_done;  // line ends with this pixel
    } t_cmd_ctl;

endpackage

`default_nettype wire

// ===== hdl/lssc_front.sv =====
// ----------------------------------------------------------------------------
// lssc_front
// Sample window and pixel counter: forms the 3, 4 and 5 point sums of each
// accepted pixel and classifies which smoothed results it releases.
// ----------------------------------------------------------------------------
`default_nettype none

module lssc_front #(
    parameter int unsigned LINE_LENGTH = lssc_pkg::LINE_LENGTH_DEF,
    parameter int unsigned SAMPLE_BITS = lssc_pkg::SAMPLE_BITS_DEF,
    localparam int unsigned IDX_W = $clog2(LINE_LENGTH),
    localparam int unsigned S_W   = SAMPLE_BITS + 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [lssc_pkg::PIXEL_W-1:0] i_pixel_sample,
    input  wire logic                         i_line_end,
    input  wire logic                         i_accept,
    output logic      [S_W-1:0]               o_s3,
    output logic      [S_W-1:0]               o_s4,
    output logic      [S_W-1:0]               o_s5,
    output logic      [IDX_W-1:0]             o_idx,
    output lssc_pkg::t_cmd_ctl                o_ctl
);

    logic [SAMPLE_BITS-1:0] r_win [4];
    logic [IDX_W-1:0]       r_count;

    logic [lssc_pkg::PIXEL_W+SAMPLE_BITS-1:0] sample_ext;
    logic [SAMPLE_BITS-1:0]                   cur;
    logic                                     line_end;

    // keep the low SAMPLE_BITS bits of the raw sample
    assign sample_ext = {{SAMPLE_BITS{1'b0}}, i_pixel_sample};
    assign cur        = sample_ext[SAMPLE_BITS-1:0];

    assign o_s3 = S_W'(cur) + S_W'(r_win[0]) + S_W'(r_win[1]);
    assign o_s4 = o_s3 + S_W'(r_win[2]);
    assign o_s5 = o_s4 + S_W'(r_win[3]);
    assign o_idx = r_count;

    // an overlong line ends on its last allowed pixel
    assign line_end = i_line_end || (r_count >= IDX_W'(LINE_LENGTH - 1));

    always_comb begin
        o_ctl.emit_main = (r_count >= IDX_W'(2));
        o_ctl.emit_prev = line_end && (r_count != '0);
        o_ctl.line_done = line_end;
        if (r_count == IDX_W'(2)) begin
            o_ctl.main_div = lssc_pkg::DIV_3;
        end else if (r_count == IDX_W'(3)) begin
            o_ctl.main_div = lssc_pkg::DIV_4;
        end else begin
            o_ctl.main_div = lssc_pkg::DIV_5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 4; k++) begin
                r_win[k] <= '0;
            end
            r_count <= '0;
        end else if (i_accept) begin
            if (line_end) begin
                for (int k = 0; k < 4; k++) begin
                    r_win[k] <= '0;
                end
                r_count <= '0;
            end else begin
                r_win[3] <= r_win[2];
                r_win[2] <= r_win[1];
                r_win[1] <= r_win[0];
                r_win[0] <= cur;
                r_count  <= r_count + IDX_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lssc_queue.sv =====
// ----------------------------------------------------------------------------
// lssc_queue
// Small first-in first-out queue of classified pixels between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_scan_smooth_centroid_assert.svh"

module lssc_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = lssc_pkg::QUEUE_DEPTH,
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int unsigned CNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_rdata,
    output logic                  o_full,
    output logic                  o_empty
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `LSSC_ASSERT_IMP(a_no_push_full, i_clk, i_rst_n, i_push, !o_full || i_pop)
    `LSSC_ASSERT_IMP(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty)

endmodule

`default_nettype wire

// ===== hdl/lssc_back.sv =====
// ----------------------------------------------------------------------------
// lssc_back
// Result sequencer: divides the window sums by 3, 4 or 5, accumulates the
// plain and index-weighted sums, runs the centroid division at line end and
// holds each result in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "line_scan_smooth_centroid_assert.svh"

module lssc_back #(
    parameter int unsigned LINE_LENGTH = lssc_pkg::LINE_LENGTH_DEF,
    parameter int unsigned SAMPLE_BITS = lssc_pkg::SAMPLE_BITS_DEF,
    localparam int unsigned IDX_W = $clog2(LINE_LENGTH),
    localparam int unsigned S_W   = SAMPLE_BITS + 3
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cmd_valid,
    output logic                              o_cmd_pop,
    input  wire logic [S_W-1:0]               i_s3,
    input  wire logic [S_W-1:0]               i_s4,
    input  wire logic [S_W-1:0]               i_s5,
    input  wire logic [IDX_W-1:0]             i_idx,
    input  wire lssc_pkg::t_cmd_ctl           i_ctl,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [lssc_pkg::PIXEL_W-1:0] o_smooth_value,
    output logic      [lssc_pkg::INDEX_W-1:0] o_pixel_index,
    output logic      [lssc_pkg::INDEX_W-1:0] o_position,
    output logic                              o_position_ok,
    output logic                              o_last_of_line
);

    localparam int unsigned SUM_W  = SAMPLE_BITS + IDX_W;
    localparam int unsigned WP_W   = SAMPLE_BITS + IDX_W;
    localparam int unsigned WSUM_W = SAMPLE_BITS + 2 * IDX_W;
    localparam int unsigned CW     = $clog2(IDX_W);
    // reciprocal multiply: x / d == (x * ceil(2^SHIFT / d)) >> SHIFT for x < 2^S_W
    localparam int unsigned SHIFT  = S_W + 3;
    localparam int unsigned RW     = S_W + 2;
    localparam int unsigned PW     = S_W + RW;
    localparam longint unsigned POW  = longint'(1) << SHIFT;
    localparam longint unsigned RCP3 = (POW + 2) / 3;
    localparam longint unsigned RCP4 = POW / 4;
    localparam longint unsigned RCP5 = (POW + 4) / 5;

    localparam int unsigned PW_X = lssc_pkg::PIXEL_W;
    localparam int unsigned IW_X = lssc_pkg::INDEX_W;

    lssc_pkg::t_back_state r_state, n_state;
    lssc_pkg::t_phase      r_phase, n_phase;

    logic [S_W-1:0]         r_s3, r_s4, r_s5;
    logic [IDX_W-1:0]       r_idx;
    lssc_pkg::t_cmd_ctl     r_ctl;
    logic [PW-1:0]          r_prod;
    logic [SAMPLE_BITS-1:0] r_v;
    logic [IDX_W-1:0]       r_oidx;
    logic [WP_W-1:0]        r_wprod;
    logic [SUM_W-1:0]       r_ssum;
    logic [WSUM_W-1:0]      r_wsum;
    logic [SUM_W-1:0]       r_rem;
    logic [IDX_W-1:0]       r_dq;
    logic [CW-1:0]          r_cnt;

    logic                   r_ovalid;
    logic [PW_X-1:0]        r_osmooth;
    logic [IW_X-1:0]        r_oindex;
    logic [IW_X-1:0]        r_opos;
    logic                   r_opos_ok;
    logic                   r_olast;

    lssc_pkg::t_div_kind    sel_kind;
    logic [S_W-1:0]         sel_sum;
    logic [RW-1:0]          sel_recip;
    logic [IDX_W-1:0]       sel_idx;
    logic                   out_free;
    logic                   emit;
    logic                   has_next;
    lssc_pkg::t_phase       next_phase;
    lssc_pkg::t_phase       start_phase;
    logic [WSUM_W-1:0]      wsum_add;
    logic [SUM_W:0]         trial;
    logic [SUM_W:0]         diff;
    logic                   trial_ge;
    logic                   is_tail;
    logic                   ssum_nz;

    logic [SAMPLE_BITS+PW_X-1:0] v_ext;
    logic [IDX_W+IW_X-1:0]       oidx_ext;
    logic [IDX_W+IW_X-1:0]       q_ext;

    // ---- operand selection for the current result
    always_comb begin
        unique case (r_phase)
            lssc_pkg::PH_MAIN: begin
                sel_kind = r_ctl.main_div;
                sel_idx  = r_idx - IDX_W'(2);
            end
            lssc_pkg::PH_PREV: begin
                sel_kind = lssc_pkg::DIV_4;
                sel_idx  = r_idx - IDX_W'(1);
            end
            default: begin
                sel_kind = lssc_pkg::DIV_3;
                sel_idx  = r_idx;
            end
        endcase
    end

    always_comb begin
        unique case (sel_kind)
            lssc_pkg::DIV_3: begin
                sel_sum   = r_s3;
                sel_recip = RW'(RCP3);
            end
            lssc_pkg::DIV_4: begin
                sel_sum   = r_s4;
                sel_recip = RW'(RCP4);
            end
            default: begin
                sel_sum   = r_s5;
                sel_recip = RW'(RCP5);
            end
        endcase
    end

    // ---- result order within one pixel
    assign start_phase = i_ctl.emit_main ? lssc_pkg::PH_MAIN :
                         (i_ctl.emit_prev ? lssc_pkg::PH_PREV : lssc_pkg::PH_TAIL);

    always_comb begin
        has_next   = 1'b0;
        next_phase = lssc_pkg::PH_TAIL;
        unique case (r_phase)
            lssc_pkg::PH_MAIN: begin
                has_next   = r_ctl.line_done;
                next_phase = r_ctl.emit_prev ? lssc_pkg::PH_PREV : lssc_pkg::PH_TAIL;
            end
            lssc_pkg::PH_PREV: begin
                has_next   = 1'b1;
                next_phase = lssc_pkg::PH_TAIL;
            end
            default: begin
                has_next   = 1'b0;
                next_phase = lssc_pkg::PH_TAIL;
            end
        endcase
    end

    assign is_tail  = (r_phase == lssc_pkg::PH_TAIL);
    assign ssum_nz  = (r_ssum != '0);
    assign out_free = !r_ovalid || i_ready;
    assign wsum_add = r_wsum + WSUM_W'(r_wprod);

    // one quotient bit per cycle
    assign trial    = {r_rem, r_dq[IDX_W-1]};
    assign diff     = trial - {1'b0, r_ssum};
    assign trial_ge = (trial >= {1'b0, r_ssum});

    // ---- sequencer
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        o_cmd_pop = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            lssc_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_phase   = start_phase;
                    if (i_ctl.emit_main || i_ctl.line_done) begin
                        n_state = lssc_pkg::ST_MUL;
                    end
                end
            end
            lssc_pkg::ST_MUL:   n_state = lssc_pkg::ST_SCALE;
            lssc_pkg::ST_SCALE: n_state = lssc_pkg::ST_WMUL;
            lssc_pkg::ST_WMUL:  n_state = lssc_pkg::ST_WADD;
            lssc_pkg::ST_WADD: begin
                n_state = (is_tail && ssum_nz) ? lssc_pkg::ST_DIV : lssc_pkg::ST_EMIT;
            end
            lssc_pkg::ST_DIV: begin
                if (r_cnt == '0) begin
                    n_state = lssc_pkg::ST_EMIT;
                end
            end
            lssc_pkg::ST_EMIT: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (has_next) begin
                        n_phase = next_phase;
                        n_state = lssc_pkg::ST_MUL;
                    end else begin
                        n_state = lssc_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = lssc_pkg::ST_IDLE;
        endcase
    end

    // ---- control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lssc_pkg::ST_IDLE;
            r_phase  <= lssc_pkg::PH_MAIN;
            r_ssum   <= '0;
            r_wsum   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            if (r_state == lssc_pkg::ST_WMUL) begin
                r_ssum <= r_ssum + SUM_W'(r_v);
            end else if (emit && is_tail) begin
                r_ssum <= '0;
            end
            if (r_state == lssc_pkg::ST_WADD) begin
                r_wsum <= wsum_add;
            end else if (emit && is_tail) begin
                r_wsum <= '0;
            end
            if (emit) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---- datapath registers
    assign v_ext    = {{PW_X{1'b0}}, r_v};
    assign oidx_ext = {{IW_X{1'b0}}, r_oidx};
    assign q_ext    = {{IW_X{1'b0}}, r_dq};

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_s3  <= i_s3;
            r_s4  <= i_s4;
            r_s5  <= i_s5;
            r_idx <= i_idx;
            r_ctl <= i_ctl;
        end
        case (r_state)
            lssc_pkg::ST_MUL: begin
                r_prod <= PW'(sel_sum) * PW'(sel_recip);
                r_oidx <= sel_idx;
            end
            lssc_pkg::ST_SCALE: begin
                r_v <= r_prod[SHIFT +: SAMPLE_BITS];
            end
            lssc_pkg::ST_WMUL: begin
                r_wprod <= WP_W'(r_v) * WP_W'(r_oidx);
            end
            lssc_pkg::ST_WADD: begin
                // high part of the dividend is already below the divisor
                r_rem <= wsum_add[WSUM_W-1:IDX_W];
                r_dq  <= wsum_add[IDX_W-1:0];
                r_cnt <= CW'(IDX_W - 1);
            end
            lssc_pkg::ST_DIV: begin
                r_rem <= trial_ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
                r_dq  <= {r_dq[IDX_W-2:0], trial_ge};
                r_cnt <= r_cnt - CW'(1);
            end
            default: ;
        endcase
        if (emit) begin
            r_osmooth <= v_ext[PW_X-1:0];
            r_oindex  <= oidx_ext[IW_X-1:0];
            r_opos    <= (is_tail && ssum_nz) ? q_ext[IW_X-1:0] : '0;
            r_opos_ok <= is_tail && ssum_nz;
            r_olast   <= is_tail;
        end
    end

    assign o_valid        = r_ovalid;
    assign o_smooth_value = r_osmooth;
    assign o_pixel_index  = r_oindex;
    assign o_position     = r_opos;
    assign o_position_ok  = r_opos_ok;
    assign o_last_of_line = r_olast;

    `LSSC_ASSERT_IMP(a_div_nonzero, i_clk, i_rst_n, r_state == lssc_pkg::ST_DIV, ssum_nz)
    `LSSC_ASSERT_IMP(a_rem_below, i_clk, i_rst_n, r_state == lssc_pkg::ST_DIV, r_rem < r_ssum)
    `LSSC_ASSERT_NXT(a_sums_cleared, i_clk, i_rst_n, emit && is_tail, (r_ssum == '0) && (r_wsum == '0))

endmodule

`default_nettype wire

// ===== hdl/line_scan_smooth_centroid.sv =====
// An accepted pixel goes into the queue; the idle back end pops it and runs each of its
// results through multiply, scale, weight, accumulate and emit, where emit waits until the
// output register is free. A new pixel is popped only when all results of the last one are out.
// The line-end pixel gives up to 3 results plus the centroid division.
// The 2-entry queue takes pixels at one per cycle until it fills.
// Reset (synchronous, active low) clears window, counter, sums, queue and output valid.
// ----------------------------------------------------------------------------
// line_scan_smooth_centroid
// Line scan smoothing with a 5-point moving average (3 and 4 point at the line
// edges) and the centroid of the smoothed line on the last result of a line.
// ----------------------------------------------------------------------------
`default_nettype none

module line_scan_smooth_centroid #(
    parameter int unsigned LINE_LENGTH = lssc_pkg::LINE_LENGTH_DEF,
    parameter int unsigned SAMPLE_BITS = lssc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // slave side: one pixel sample per request
    input  wire logic                             i_s_axis_tvalid,
    output logic                                  o_s_axis_tready,
    input  wire logic [lssc_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,  // [13:0] pixel_sample
    input  wire logic                             i_s_axis_tlast,  // line_end
    // master side: one smoothed pixel per request
    output logic                                  o_m_axis_tvalid,
    input  wire logic                             i_m_axis_tready,
    // [13:0] smooth_value, [20:14] pixel_index, [27:21] position
    output logic      [lssc_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    output logic                                  o_m_axis_tuser,  // position_ok
    output logic                                  o_m_axis_tlast   // last_of_line
);

    localparam int unsigned IDX_W = $clog2(LINE_LENGTH);
    localparam int unsigned S_W   = SAMPLE_BITS + 3;
    localparam int unsigned CTL_W = $bits(lssc_pkg::t_cmd_ctl);
    localparam int unsigned Q_W   = 3 * S_W + IDX_W + CTL_W;
    localparam int unsigned PAD_W = lssc_pkg::OUT_TDATA_W - lssc_pkg::PIXEL_W
                                    - 2 * lssc_pkg::INDEX_W;

    // front to queue
    logic [S_W-1:0]         f_s3, f_s4, f_s5;
    logic [IDX_W-1:0]       f_idx;
    lssc_pkg::t_cmd_ctl     f_ctl;
    logic                   in_accept;

    // queue to back
    logic [Q_W-1:0]         q_wdata;
    logic [Q_W-1:0]         q_rdata;
    logic                   q_full;
    logic                   q_empty;
    logic                   q_pop;
    logic [S_W-1:0]         b_s3, b_s4, b_s5;
    logic [IDX_W-1:0]       b_idx;
    lssc_pkg::t_cmd_ctl     b_ctl;

    // result fields
    logic [lssc_pkg::PIXEL_W-1:0] smooth_value;
    logic [lssc_pkg::INDEX_W-1:0] pixel_index;
    logic [lssc_pkg::INDEX_W-1:0] position;

    // Take a pixel whenever the queue has room; the window updates only on an accepted
    // pixel, so a full queue holds up classification and the input.
    assign o_s_axis_tready = !q_full;
    assign in_accept       = i_s_axis_tvalid && !q_full;

    lssc_front #(
        .LINE_LENGTH (LINE_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_pixel_sample (i_s_axis_tdata[lssc_pkg::PIXEL_W-1:0]),
        .i_line_end     (i_s_axis_tlast),
        .i_accept       (in_accept),
        .o_s3           (f_s3),
        .o_s4           (f_s4),
        .o_s5           (f_s5),
        .o_idx          (f_idx),
        .o_ctl          (f_ctl)
    );

    // Pack the window sums, pixel index and classification into one entry.
    assign q_wdata = {f_ctl, f_idx, f_s5, f_s4, f_s3};

    lssc_queue #(
        .WIDTH (Q_W),
        .DEPTH (lssc_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    assign b_s3  = q_rdata[S_W-1:0];
    assign b_s4  = q_rdata[2*S_W-1:S_W];
    assign b_s5  = q_rdata[3*S_W-1:2*S_W];
    assign b_idx = q_rdata[3*S_W+IDX_W-1:3*S_W];
    assign b_ctl = q_rdata[Q_W-1:3*S_W+IDX_W];

    // Back end: one result at a time through the divide-by-constant, the
    // accumulators and, on the last result of a line, the centroid divider.
    lssc_back #(
        .LINE_LENGTH (LINE_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_valid    (!q_empty),
        .o_cmd_pop      (q_pop),
        .i_s3           (b_s3),
        .i_s4           (b_s4),
        .i_s5           (b_s5),
        .i_idx          (b_idx),
        .i_ctl          (b_ctl),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_smooth_value (smooth_value),
        .o_pixel_index  (pixel_index),
        .o_position     (position),
        .o_position_ok  (o_m_axis_tuser),
        .o_last_of_line (o_m_axis_tlast)
    );

    // Pack the result fields, lowest field first, zero padded to whole bytes.
    assign o_m_axis_tdata = {{PAD_W{1'b0}}, position, pixel_index, smooth_value};

endmodule

`default_nettype wire
